@@ rtl/acsi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ANSI CSI console parser.
// No dependencies; imported by acsi_parser_core and ansi_escape_console_parser.
package acsi_pkg;

  localparam int unsigned PARAM_WIDTH_DEF = 8;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP     = 8'h41;  // 'A'
  localparam logic [7:0] CH_DOWN   = 8'h42;  // 'B'
  localparam logic [7:0] CH_RIGHT  = 8'h43;  // 'C'
  localparam logic [7:0] CH_LEFT   = 8'h44;  // 'D'
  localparam logic [7:0] CH_SETPOS = 8'h48;  // 'H'
  localparam logic [7:0] CH_ERDISP = 8'h4A;  // 'J'
  localparam logic [7:0] CH_ERLINE = 8'h4B;  // 'K'

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } parse_mode_e;

  typedef enum logic [2:0] {
    CMD_PRINT       = 3'd0,
    CMD_SET_CURSOR  = 3'd1,
    CMD_MOVE_CURSOR = 3'd2,
    CMD_HOME_CLEAR  = 3'd3,
    CMD_CLEAR_SCR   = 3'd4,
    CMD_CLEAR_LINE  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic              valid;
    cmd_e              command;
    logic [7:0]        char_code;
    logic signed [8:0] col_value;
    logic signed [8:0] row_value;
  } acsi_result_t;

endpackage

@@ rtl/acsi_parser_core.sv @@
`timescale 1ns / 1ps
// Parser state registers and the per-byte decode logic.
// Depends on acsi_pkg; instantiated by ansi_escape_console_parser.
module acsi_parser_core import acsi_pkg::*; #(
  parameter int unsigned PARAM_WIDTH = PARAM_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   data_byte_i,
  output acsi_result_t result_o
);

  localparam int unsigned AW = PARAM_WIDTH + 4;

  parse_mode_e            mode_q, mode_d;
  logic [1:0]             idx_q, idx_d;
  logic [PARAM_WIDTH-1:0] first_q, first_d;
  logic [PARAM_WIDTH-1:0] second_q, second_d;

  logic                   is_digit;
  logic [PARAM_WIDTH-1:0] slot;
  logic [AW-1:0]          acc_raw;
  logic [PARAM_WIDTH-1:0] acc;
  logic [PARAM_WIDTH-1:0] first_def, second_def, second_h;
  logic [PARAM_WIDTH+8:0] first_ext, second_ext;
  logic [8:0]             p9, s9;
  logic [PARAM_WIDTH-1:0] one_w;
  logic [PARAM_WIDTH-1:0] two_w;

  assign one_w = {{(PARAM_WIDTH-1){1'b0}}, 1'b1};
  assign two_w = {{(PARAM_WIDTH-2){1'b0}}, 2'b10};

  assign is_digit = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign slot     = (idx_q == 2'd0) ? first_q : second_q;
  // slot * 10 + digit, built from shifts.
  assign acc_raw  = {1'b0, slot, 3'b000} + {3'b000, slot, 1'b0}
                    + {{(AW-4){1'b0}}, data_byte_i[3:0]};
  assign acc      = (acc_raw[AW-1:PARAM_WIDTH] != '0) ? {PARAM_WIDTH{1'b1}}
                                                      : acc_raw[PARAM_WIDTH-1:0];

  // A parameter still at zero when a non-digit arrives counts as one.
  assign first_def  = ((idx_q == 2'd0) && (first_q == '0)) ? one_w : first_q;
  assign second_def = ((idx_q == 2'd1) && (second_q == '0)) ? one_w : second_q;
  assign second_h   = (second_def == '0) ? one_w : second_def;

  // Only the low nine bits of a parameter reach the signed results.
  assign first_ext  = {9'd0, first_def};
  assign second_ext = {9'd0, second_h};
  assign p9         = first_ext[8:0];
  assign s9         = second_ext[8:0];

  always_comb begin
    mode_d   = mode_q;
    idx_d    = idx_q;
    first_d  = first_q;
    second_d = second_q;
    result_o = '0;
    result_o.command = CMD_PRINT;
    unique case (mode_q)
      MODE_ESC: begin
        if (data_byte_i == CH_LBRACK) begin
          mode_d = MODE_CSI;
        end else begin
          mode_d             = MODE_TEXT;
          result_o.valid     = 1'b1;
          result_o.char_code = data_byte_i;
        end
      end
      MODE_CSI: begin
        if (is_digit) begin
          if (idx_q == 2'd0) begin
            first_d = acc;
          end else if (idx_q == 2'd1) begin
            second_d = acc;
          end
        end else begin
          first_d  = first_def;
          second_d = second_def;
          if (data_byte_i == CH_SEMI) begin
            // A third parameter abandons the sequence.
            if (idx_q != 2'd0) begin
              idx_d  = 2'd2;
              mode_d = MODE_TEXT;
            end else begin
              idx_d = 2'd1;
            end
          end else begin
            mode_d = MODE_TEXT;
            unique case (data_byte_i)
              CH_SETPOS: begin
                second_d           = second_h;
                result_o.valid     = 1'b1;
                result_o.command   = CMD_SET_CURSOR;
                result_o.col_value = s9 - 9'd1;
                result_o.row_value = p9 - 9'd1;
              end
              CH_UP: begin
                result_o.valid     = 1'b1;
                result_o.command   = CMD_MOVE_CURSOR;
                result_o.row_value = 9'd0 - p9;
              end
              CH_DOWN: begin
                result_o.valid     = 1'b1;
                result_o.command   = CMD_MOVE_CURSOR;
                result_o.row_value = p9;
              end
              CH_RIGHT: begin
                result_o.valid     = 1'b1;
                result_o.command   = CMD_MOVE_CURSOR;
                result_o.col_value = p9;
              end
              CH_LEFT: begin
                result_o.valid     = 1'b1;
                result_o.command   = CMD_MOVE_CURSOR;
                result_o.col_value = 9'd0 - p9;
              end
              CH_ERDISP: begin
                if (first_def == two_w) begin
                  result_o.valid   = 1'b1;
                  result_o.command = CMD_HOME_CLEAR;
                end else if (first_def == one_w) begin
                  result_o.valid   = 1'b1;
                  result_o.command = CMD_CLEAR_SCR;
                end
              end
              CH_ERLINE: begin
                result_o.valid   = 1'b1;
                result_o.command = CMD_CLEAR_LINE;
              end
              default: begin
                result_o.valid     = 1'b1;
                result_o.char_code = data_byte_i;
              end
            endcase
          end
        end
      end
      default: begin
        // Plain text, and the unused mode code behaves the same way.
        mode_d = MODE_TEXT;
        if (data_byte_i == CH_ESC) begin
          mode_d   = MODE_ESC;
          idx_d    = 2'd0;
          first_d  = '0;
          second_d = '0;
        end else begin
          result_o.valid     = 1'b1;
          result_o.char_code = data_byte_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TEXT;
      idx_q    <= 2'd0;
      first_q  <= '0;
      second_q <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      idx_q    <= idx_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

@@ rtl/ansi_escape_console_parser.sv @@
`timescale 1ns / 1ps
// Top level of the ANSI CSI console parser: input register, parser core, result register.
// Depends on acsi_pkg and acsi_parser_core.

// The block takes one console byte per item and accepts a new byte every
// cycle while results keep flowing; a byte produces at most one result,
// which passes through the input register and then the result register.
// Plain bytes come out as print commands; ESC [ sequences with up to two
// decimal parameters and the finals H, A, B, C, D, J (for parameter 1 or
// 2 only) and K come out as cursor and clear commands, the kind being
// carried on tuser. Parameters saturate at 2^PARAM_WIDTH-1 and a zero
// parameter counts as one. Back-pressure on the result side stalls the
// parser, and the input side stalls once its register is full.
module ansi_escape_console_parser import acsi_pkg::*; #(
  parameter int unsigned PARAM_WIDTH = PARAM_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] char_code, [16:8] col_value,
                                        // [25:17] row_value, [31:26] zero
  output logic [2:0]  m_axis_tuser_o    // [2:0] command
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  acsi_result_t out_q;
  acsi_result_t result;
  logic         advance;

  // The buffered item moves on when the result register is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  acsi_parser_core #(
    .PARAM_WIDTH(PARAM_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .data_byte_i(in_byte_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result.valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.command;
  assign m_axis_tdata_o  = {6'd0, out_q.row_value, out_q.col_value, out_q.char_code};

endmodule
